// ----- rtl/bdl_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants for the BCD digit latch driver.
// No dependencies; used by the interfaces, bdl_div_stage and the top level.
package bdl_pkg;

   localparam int MAX_DIGITS_DEF = 10;
   localparam int VALUE_W        = 32;
   localparam int DIGIT_W        = 4;
   localparam int INDEX_W        = 4;
   localparam int COUNT_W        = 4;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd3;

   // Reciprocal of ten for 32-bit unsigned values: x / 10 == (x * RECIP) >> RECIP_SHIFT.
   localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;

endpackage

// ----- rtl/bdl_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the BCD digit latch driver: value in, digit out, count write.
// Depends on bdl_pkg for field widths.
interface bdl_req_if;
   logic                             valid;
   logic                             ready;
   logic [bdl_pkg::VALUE_W-1:0]      value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

interface bdl_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bdl_pkg::DIGIT_W-1:0]      digit_value;
   logic [bdl_pkg::INDEX_W-1:0]      latch_index;
   logic                             last_digit;
   modport source (output valid, output digit_value, output latch_index, output last_digit,
                   input ready);
   modport sink (input valid, input digit_value, input latch_index, input last_digit,
                 output ready);
endinterface

interface bdl_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bdl_pkg::COUNT_W-1:0]      data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/bdl_div_stage.sv -----
`timescale 1ns / 1ps
// One pipeline stage: divide by ten with a reciprocal multiply, keep the remainder as digit STAGE.
// Depends on bdl_pkg.
module bdl_div_stage #(
   parameter int MAX_DIGITS = bdl_pkg::MAX_DIGITS_DEF,
   parameter int STAGE      = 0
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_ready,
   input  logic [bdl_pkg::VALUE_W-1:0]                      in_x,
   input  logic [MAX_DIGITS-1:0][bdl_pkg::DIGIT_W-1:0]      in_digits,
   output logic                                             out_valid,
   input  logic                                             out_ready,
   output logic [bdl_pkg::VALUE_W-1:0]                      out_x,
   output logic [MAX_DIGITS-1:0][bdl_pkg::DIGIT_W-1:0]      out_digits
);

   logic [63:0]                                  prod;
   logic [bdl_pkg::VALUE_W-1:0]                  quot;
   logic [bdl_pkg::DIGIT_W-1:0]                  ten_q;
   logic [bdl_pkg::DIGIT_W-1:0]                  rem;
   logic [MAX_DIGITS-1:0][bdl_pkg::DIGIT_W-1:0]  digits_in;
   logic                                         valid_ff;
   logic [bdl_pkg::VALUE_W-1:0]                  x_ff;
   logic [MAX_DIGITS-1:0][bdl_pkg::DIGIT_W-1:0]  digits_ff;

   assign prod  = 64'(in_x) * 64'(bdl_pkg::RECIP);
   assign quot  = bdl_pkg::VALUE_W'(prod[63:bdl_pkg::RECIP_SHIFT]);
   // only the low nibble of x - 10q is needed, since the remainder is below ten
   assign ten_q = 4'({quot[3:0], 3'b000}) + 4'({quot[3:0], 1'b0});
   assign rem   = in_x[3:0] - ten_q;

   always_comb begin
      digits_in        = in_digits;
      digits_in[STAGE] = rem;
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         x_ff      <= quot;
         digits_ff <= digits_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_x      = x_ff;
   assign out_digits = digits_ff;

endmodule

// ----- rtl/bcd_digit_latch_driver_top.sv -----
`timescale 1ns / 1ps
// A value word passes the divide stages, the digit buffer and the output register.
// Throughput: one digit word per cycle while rsp_bus.ready is high; a value gives
// digit_count digit words. Each of the MAX_DIGITS divide stages holds one reciprocal
// multiply; the output side is one digit buffer and one output register. Synchronous
// active-high reset empties the pipeline and sets digit_count to 3.
module bcd_digit_latch_driver_top #(
   parameter int MAX_DIGITS = bdl_pkg::MAX_DIGITS_DEF
) (
   input  logic   clock,
   input  logic   reset,
   bdl_req_if.sink   req_bus,
   bdl_rsp_if.source rsp_bus,
   bdl_csr_if.sink   csr_bus
);

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [bdl_pkg::COUNT_W-1:0] COUNT_MAX = bdl_pkg::COUNT_W'(MAX_DIGITS);

   logic [bdl_pkg::COUNT_W-1:0]                   count_ff;
   logic [bdl_pkg::COUNT_W-1:0]                   count_in;

   logic [MAX_DIGITS:0]                           st_valid;
   logic [MAX_DIGITS:0]                           st_ready;
   logic [MAX_DIGITS:0][bdl_pkg::VALUE_W-1:0]     st_x;
   logic [MAX_DIGITS:0][MAX_DIGITS-1:0][bdl_pkg::DIGIT_W-1:0] st_digits;

   logic                                          buf_valid_ff;
   logic [MAX_DIGITS-1:0][bdl_pkg::DIGIT_W-1:0]   buf_digits_ff;
   logic [bdl_pkg::COUNT_W-1:0]                   buf_count_ff;
   logic [IDX_W-1:0]                              idx_ff;
   logic                                          buf_last;
   logic                                          buf_free;
   logic                                          out_load;
   logic                                          out_open;

   logic                                          rsp_valid_ff;
   logic [bdl_pkg::DIGIT_W-1:0]                   rsp_digit_ff;
   logic [bdl_pkg::INDEX_W-1:0]                   rsp_index_ff;
   logic                                          rsp_last_ff;

   // digit count register, saturating at both ends
   assign csr_bus.ready = 1'b1;

   always_comb begin
      priority if (csr_bus.data == '0) begin
         count_in = bdl_pkg::COUNT_W'(1);
      end else if (csr_bus.data > COUNT_MAX) begin
         count_in = COUNT_MAX;
      end else begin
         count_in = csr_bus.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= bdl_pkg::COUNT_RESET;
      end else if (csr_bus.valid) begin
         count_ff <= count_in;
      end
   end

   // divide pipeline
   assign st_valid[0]  = req_bus.valid;
   assign req_bus.ready = st_ready[0];
   assign st_x[0]      = req_bus.value;
   assign st_digits[0] = '0;

   for (genvar g = 0; g < MAX_DIGITS; g++) begin : g_stage
      bdl_div_stage #(
         .MAX_DIGITS (MAX_DIGITS),
         .STAGE      (g)
      ) u_stage (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (st_valid[g]),
         .in_ready   (st_ready[g]),
         .in_x       (st_x[g]),
         .in_digits  (st_digits[g]),
         .out_valid  (st_valid[g+1]),
         .out_ready  (st_ready[g+1]),
         .out_x      (st_x[g+1]),
         .out_digits (st_digits[g+1])
      );
   end

   // digit buffer: step through the digits of one value
   assign out_open = !rsp_valid_ff || rsp_bus.ready;
   assign out_load = buf_valid_ff && out_open;
   assign buf_last = (bdl_pkg::COUNT_W'(idx_ff) + bdl_pkg::COUNT_W'(1)) == buf_count_ff;
   assign buf_free = !buf_valid_ff || (out_load && buf_last);
   assign st_ready[MAX_DIGITS] = buf_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else if (buf_free) begin
         buf_valid_ff <= st_valid[MAX_DIGITS];
         idx_ff       <= '0;
      end else if (out_load) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (buf_free && st_valid[MAX_DIGITS]) begin
         buf_digits_ff <= st_digits[MAX_DIGITS];
         buf_count_ff  <= count_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= buf_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_digit_ff <= buf_digits_ff[idx_ff];
         rsp_index_ff <= bdl_pkg::INDEX_W'(idx_ff);
         rsp_last_ff  <= buf_last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.digit_value = rsp_digit_ff;
   assign rsp_bus.latch_index = rsp_index_ff;
   assign rsp_bus.last_digit  = rsp_last_ff;

`ifndef SYNTHESIS
   a_digit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_digit_ff <= bdl_pkg::DIGIT_W'(9))
      else $error("digit word out of BCD range");

   a_last_index : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |->
         (bdl_pkg::COUNT_W'(rsp_index_ff) + bdl_pkg::COUNT_W'(1)) == count_ff)
      else $error("last digit word at wrong latch index");

   a_next_digit : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bus.ready && !rsp_last_ff) |=>
         (rsp_valid_ff && rsp_index_ff == $past(rsp_index_ff) + bdl_pkg::INDEX_W'(1)))
      else $error("digit words of one value not contiguous");
`endif

endmodule

// ----- tb/tb_bcd_digit_latch_driver_top.sv -----
`timescale 1ns / 1ps
// Self-checking bench for bcd_digit_latch_driver_top: values in, decimal digit words out.
// Depends on bdl_pkg and the channel interfaces in bdl_if.sv; predicts each digit word
// from the value and the clamped digit count, and compares in order.
module tb_bcd_digit_latch_driver_top;

   localparam int MAX_DIGITS  = bdl_pkg::MAX_DIGITS_DEF;
   localparam int IDLE_LIMIT  = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int PHASE_ITEMS = 28;

   typedef struct packed {
      logic [bdl_pkg::DIGIT_W-1:0] digit;
      logic [bdl_pkg::INDEX_W-1:0] index;
      logic                        last;
   } digit_word_type;

   logic clock;
   logic reset;

   bdl_req_if req_bus();
   bdl_rsp_if rsp_bus();
   bdl_csr_if csr_bus();

   bcd_digit_latch_driver_top #(.MAX_DIGITS(MAX_DIGITS)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [bdl_pkg::VALUE_W-1:0] value_q[$];
   digit_word_type              digits_q[$];
   int                          digit_count_now;
   int                          err_count;
   int                          values_taken;
   int                          digits_checked;
   int                          count_writes;
   logic                        req_taken;
   int                          idle_cycles;

   int                          burst_left;
   int                          gap_left;
   int                          stall_ask;
   int                          stall_seen;
   int                          hold_left;
   int                          rx_mode;
   int                          rx_mode_left;
   int                          rx_phase;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int clamp_count(input logic [bdl_pkg::COUNT_W-1:0] data);
      if (data < 1) return 1;
      if (data > MAX_DIGITS) return MAX_DIGITS;
      return int'(data);
   endfunction

   function automatic void expand_value(input logic [bdl_pkg::VALUE_W-1:0] value,
                                        input int count);
      logic [bdl_pkg::VALUE_W-1:0] rest;
      digit_word_type              w;
      rest = value;
      for (int i = 0; i < count; i++) begin
         w.digit = bdl_pkg::DIGIT_W'(rest % 10);
         w.index = bdl_pkg::INDEX_W'(i);
         w.last  = (i == count - 1);
         digits_q.push_back(w);
         rest = rest / 10;
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] mismatch: %s got %0d expected %0d (value #%0d)",
               $time, what, got, want, values_taken);
      err_count++;
   endtask

   // check outgoing digit words, then predict for a newly taken value
   always @(posedge clock) begin
      digit_word_type want;
      if (reset) begin
         digit_count_now <= clamp_count(bdl_pkg::COUNT_RESET);
         req_taken       <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (digits_q.size() == 0) begin
               report_mismatch("unexpected digit word, digit", rsp_bus.digit_value, 0);
            end else begin
               want = digits_q.pop_front();
               if (rsp_bus.digit_value !== want.digit)
                  report_mismatch("digit_value", rsp_bus.digit_value, want.digit);
               if (rsp_bus.latch_index !== want.index)
                  report_mismatch("latch_index", rsp_bus.latch_index, want.index);
               if (rsp_bus.last_digit !== want.last)
                  report_mismatch("last_digit", rsp_bus.last_digit, want.last);
               digits_checked++;
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            expand_value(req_bus.value, digit_count_now);
            values_taken++;
         end
         if (csr_bus.valid && csr_bus.ready)
            digit_count_now <= clamp_count(csr_bus.data);
         req_taken <= req_bus.valid && req_bus.ready;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[%0t] timeout: no word moved for %0d cycles", $time, idle_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // sender: bursts of values with random gaps
   always @(negedge clock) begin
      if (req_bus.valid && !req_taken) begin
         // hold the offered word
      end else if (gap_left > 0) begin
         req_bus.valid <= 1'b0;
         gap_left      <= gap_left - 1;
      end else if (value_q.size() > 0) begin
         req_bus.valid <= 1'b1;
         req_bus.value <= value_q.pop_front();
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         req_bus.valid <= 1'b0;
      end
   end

   // receiver: changing stall pattern, plus a long hold on request
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left     <= hold_left - 1;
      end else if (stall_seen != stall_ask) begin
         rsp_bus.ready <= 1'b0;
         stall_seen    <= stall_ask;
         hold_left     <= LONG_HOLD;
      end else begin
         if (rx_mode_left <= 0) begin
            rx_mode      <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(20, 80);
         end else begin
            rx_mode_left <= rx_mode_left - 1;
         end
         rx_phase <= rx_phase + 1;
         case (rx_mode)
            0: begin
               rsp_bus.ready <= 1'b1;
            end
            1: begin
               rsp_bus.ready <= 1'($urandom_range(0, 1));
            end
            default: begin
               rsp_bus.ready <= (rx_phase % 4 == 0);
            end
         endcase
      end
   end

   function automatic logic [bdl_pkg::VALUE_W-1:0] pick_value();
      logic [bdl_pkg::VALUE_W-1:0] p;
      int                          k;
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 999);
         2: begin
            p = 1;
            k = $urandom_range(0, 9);
            for (int i = 0; i < k; i++) p = p * 10;
            return p - $urandom_range(0, 1);
         end
         3: return 32'hFFFF_FFFF - $urandom_range(0, 1000);
         default: return $urandom >> $urandom_range(0, 31);
      endcase
   endfunction

   task automatic write_digit_count(input logic [bdl_pkg::COUNT_W-1:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= data;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      count_writes++;
   endtask

   task automatic wait_drained();
      while (value_q.size() != 0 || req_bus.valid || digits_q.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      logic [bdl_pkg::COUNT_W-1:0] phase_counts[$];
      logic [bdl_pkg::COUNT_W-1:0] cnt;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.value   = '0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = '0;
      err_count       = 0;
      values_taken    = 0;
      digits_checked  = 0;
      count_writes    = 0;
      idle_cycles     = 0;
      burst_left      = 0;
      gap_left        = 0;
      stall_ask       = 0;
      stall_seen      = 0;
      hold_left       = 0;
      rx_mode         = 0;
      rx_mode_left    = 0;
      rx_phase        = 0;
      digit_count_now = 3;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset count of three digits
      @(posedge clock);
      value_q = '{32'd0, 32'd9, 32'd10, 32'd999, 32'd1000, 32'hFFFF_FFFF, 32'd1234567890};
      wait_drained();

      // zero count clamps to one digit
      write_digit_count(4'd0);
      @(posedge clock);
      value_q = '{32'd0, 32'd9, 32'hFFFF_FFFF};
      wait_drained();

      // count above the maximum clamps to ten digits
      write_digit_count(4'd15);
      @(posedge clock);
      value_q = '{32'd0, 32'hFFFF_FFFF, 32'd999999999, 32'd1000000000, 32'h8000_0000,
                  32'h5555_5555, 32'hAAAA_AAAA};
      wait_drained();

      phase_counts = '{4'd10, 4'd1, 4'd5, 4'd15, 4'd2, 4'd0, 4'd7, 4'd11, 4'd9, 4'd4,
                       4'd6, 4'd8, 4'd3};
      foreach (phase_counts[p]) begin
         cnt = phase_counts[p];
         write_digit_count(cnt);
         @(posedge clock);
         for (int i = 0; i < PHASE_ITEMS; i++) value_q.push_back(pick_value());
         // stall the output while values keep coming
         if (p == 0) stall_ask++;
         wait_drained();
      end

      repeat (MAX_DIGITS + 4) @(posedge clock);
      while (digits_q.size() > 0) begin
         digit_word_type left_over;
         left_over = digits_q.pop_front();
         report_mismatch("missing digit word, latch", 'x, left_over.index);
      end
      $display("Ran %0d values through %0d digit-count writes (zero, over-range, 1..10)",
               values_taken, count_writes);
      $display("and checked %0d digit words, with one long output stall.", digits_checked);
      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
